FILE: rtl/core/sts_pkg.sv
// types and constants shared by the sorted table search block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

  localparam int IDX_W = 8;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int CNT_W = 9;
  localparam int DATA_W = 32;
  localparam int POS_W = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] data_value;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/sts_table.sv
// table storage: one write port and one read port, read data registered
// depends on sts_pkg for the control struct
`timescale 1ns / 1ps
`default_nettype none

module sts_table #(
  parameter int DEPTH = 256,
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic              clk,
  input  sts_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [DW-1:0]     wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DW-1:0]     rdata
);
  import sts_pkg::*;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sts_ctrl.sv
// search sequencer: takes beats, issues one table probe per cycle, forms the result
// depends on sts_pkg; drives sts_table through mem_ctl_t
`timescale 1ns / 1ps
`default_nettype none

module sts_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sts_pkg::item_t            item,
  input  logic [sts_pkg::CNT_W-1:0] entry_count,
  output logic                      done,
  output sts_pkg::result_t          result,
  output sts_pkg::mem_ctl_t         mem_ctl,
  output logic [AW-1:0]             mem_waddr,
  output logic [DW-1:0]             mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  logic [DW-1:0]             mem_rdata
);
  import sts_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEARCH = 1'b1;
  localparam int CNT_CAP = (DEPTH > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : DEPTH;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] low;
  logic [CNT_W-1:0] low_next;
  logic [CNT_W-1:0] hi1;
  logic [CNT_W-1:0] hi1_next;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] mid_next;
  logic [DW-1:0]    key;
  logic             done_next;
  result_t          result_next;

  logic             accept;
  logic [CNT_W-1:0] n_used;
  logic [CNT_W:0]   mid_sum;
  logic             probe_eq;
  logic             probe_lt;
  logic [DW-1:0]    item_word;
  logic [AW-1:0]    wrap_tab [IDX_SPAN];

  // write index wraps modulo the table depth
  for (genvar i = 0; i < IDX_SPAN; i++) begin : g_wrap
    assign wrap_tab[i] = AW'(i % DEPTH);
  end

  assign busy = (state == ST_SEARCH);
  assign accept = start && !busy;
  assign item_word = DW'($unsigned(item.data_value));
  assign n_used = (entry_count > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : entry_count;

  assign probe_eq = (mem_rdata == key);
  assign probe_lt = ($signed(key) < $signed(mem_rdata));

  // hi1 is one past the upper bound, so the live range is low <= i < hi1
  assign mid_sum = {1'b0, low_next} + {1'b0, hi1_next} - (CNT_W + 1)'(1);
  assign mid_next = mid_sum[CNT_W:1];

  assign mem_waddr = wrap_tab[item.entry_index];
  assign mem_wdata = item_word;
  assign mem_raddr = AW'(mid_next);

  always_comb begin
    state_next = state;
    low_next = low;
    hi1_next = hi1;
    done_next = 1'b0;
    result_next = result;
    mem_ctl.wr_en = 1'b0;
    mem_ctl.rd_en = 1'b0;
    case (state)
      ST_IDLE: begin
        low_next = '0;
        hi1_next = n_used;
        if (accept) begin
          if (item.cmd == CMD_WRITE) begin
            mem_ctl.wr_en = 1'b1;
          end else if (n_used == '0) begin
            done_next = 1'b1;
            result_next = '0;
          end else begin
            mem_ctl.rd_en = 1'b1;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (probe_eq) begin
          done_next = 1'b1;
          result_next.found = 1'b1;
          result_next.position = mid[POS_W-1:0];
          state_next = ST_IDLE;
        end else begin
          if (probe_lt) begin
            hi1_next = mid;
          end else begin
            low_next = mid + CNT_W'(1);
          end
          if (low_next < hi1_next) begin
            mem_ctl.rd_en = 1'b1;
          end else begin
            done_next = 1'b1;
            result_next = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    low <= low_next;
    hi1 <= hi1_next;
    mid <= mid_next;
    result <= result_next;
    if (accept) begin
      key <= item_word;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sorted_table_binary_search.sv
// channel   signals                     handshake
// ------    -------------------------   ----------------------------------------
// item      start, busy, item           taken at an edge with start high, busy low
// result    done, result                one-cycle strobe on done, never held off
// config    cfg_wr_en, cfg_wr_data      entry_count written at an edge with cfg_wr_en
//
// a write beat leaves busy low and gives no result. a search beat gives its
// result after p probes, with p <= floor(log2(n)) + 1 for n entries in use;
// one probe per cycle, bounded by the single read port of the table. busy is
// high while probing. reset clears the sequencer and entry_count; table
// contents stay undefined until written, with no clearing pass. results
// cannot be stalled.
//
// top level: sorted table with binary search
// depends on sts_pkg, sts_table, sts_ctrl
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  sts_pkg::item_t            item,
  output logic                      done,
  output sts_pkg::result_t          result,
  input  logic                      cfg_wr_en,
  input  logic [sts_pkg::CNT_W-1:0] cfg_wr_data
);
  import sts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CNT_W-1:0]      entry_count;
  mem_ctl_t              mem_ctl;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic [VALUE_BITS-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr_en) begin
      entry_count <= cfg_wr_data;
    end
  end

  sts_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (VALUE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .item        (item),
    .entry_count (entry_count),
    .done        (done),
    .result      (result),
    .mem_ctl     (mem_ctl),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  sts_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (VALUE_BITS)
  ) u_table (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sts_chk.sv
// port-level checks for sorted_table_binary_search, attached by bind
// depends on sts_pkg and the top level's ports
`timescale 1ns / 1ps
`default_nettype none

module sts_chk (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input sts_pkg::item_t   item,
  input logic             done,
  input sts_pkg::result_t result
);
  import sts_pkg::*;

  // a result beat only appears once probing is over
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.position == '0))
    else $error("miss with nonzero position");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_WRITE) |=> !done)
    else $error("write beat produced a result");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && item.cmd == CMD_SEARCH))
    else $error("busy without a search beat");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!done && !busy))
    else $error("activity right after reset");

endmodule

bind sorted_table_binary_search sts_chk u_sts_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for sorted_table_binary_search: directed rows, then random
// table fills and searches, each result beat checked against a behavioral search
// model or a pinned answer. depends on sts_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_top;
  import sts_pkg::*;

  localparam int DEPTH = IDX_SPAN;
  localparam int TARGET_ITEMS = 850;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT = 400;
  localparam int MAX_GAP = 12;
  localparam int COUNT_ALL_ONES = (1 << CNT_W) - 1;
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VAL_MAX = ~VAL_MIN;

  typedef enum logic [0:0] {ROW_BEAT, ROW_COUNT} row_kind_e;

  typedef struct {
    row_kind_e kind;
    item_t     beat;
    logic      pinned;
    result_t   answer;
    int        count_value;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  item_t            item = '0;
  logic             done;
  result_t          result;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;

  // shadow of the table and of entry_count as the block should hold them
  logic signed [DATA_W-1:0] entry_mirror [DEPTH];
  logic [CNT_W-1:0]         count_mirror = '0;
  result_t                  pending_results [$];
  stim_row_t                directed_rows [$];

  // a pinned answer replaces the predicted one for the beat being offered
  logic    pin_en = 1'b0;
  result_t pin_result = '0;

  int errors = 0;
  int searches = 0;
  int hits = 0;
  int stall_cycles = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int idle_modes [3] = '{0, 58, 21};

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH),
    .VALUE_BITS(DATA_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t search_table(logic signed [DATA_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    result_t r;
    r = '0;
    lo = 0;
    hi = (count_mirror > DEPTH) ? DEPTH - 1 : int'(count_mirror) - 1;
    while (lo <= hi && !r.found) begin
      mid = (lo + hi) / 2;
      if (entry_mirror[mid] == key) begin
        r.found = 1'b1;
        r.position = mid[POS_W-1:0];
      end else if (key < entry_mirror[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      count_mirror = '0;
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (cfg_wr_en) begin
        count_mirror = cfg_wr_data;
        stall_cycles = 0;
      end
      if (start && !busy) begin
        stall_cycles = 0;
        if (item.cmd == CMD_WRITE) begin
          entry_mirror[item.entry_index] = item.data_value;
        end else begin
          pending_results.push_back(pin_en ? pin_result : search_table(item.data_value));
          searches++;
        end
      end
      if (done) begin
        stall_cycles = 0;
        if (pending_results.size() == 0) begin
          $error("result beat with no search outstanding: found %0d position %0d",
                 result.found, result.position);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (result.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, result.found);
            errors++;
          end
          if (result.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, result.position);
            errors++;
          end
          if (want.found) hits++;
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles with no beat, %0d results outstanding",
                 stall_cycles, pending_results.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_beat(input item_t beat, input logic pinned, input result_t answer);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(MAX_GAP, 1);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    item <= beat;
    pin_en = pinned;
    pin_result = answer;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // hold off the sender until every search result is back
  task automatic drain(input int settle);
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_count(input int n);
    drain(SETTLE_CYCLES);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n[CNT_W-1:0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ascending values from the bottom of the range, with runs of duplicates
  task automatic fill_sorted(input int n);
    longint      level;
    int unsigned step_cap;
    item_t       beat;
    if (n > 0) begin
      step_cap = ($urandom_range(3) == 0) ? 4 : 32'hFFFF_FFFF / n;
      level = -64'sd2147483648;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) != 0) level += $urandom_range(step_cap, 0);
        beat.cmd = CMD_WRITE;
        beat.entry_index = i[IDX_W-1:0];
        beat.data_value = level[DATA_W-1:0];
        send_beat(beat, 1'b0, '0);
      end
    end
  endtask

  task automatic run_searches(input int n, input int beats);
    item_t beat;
    int    pick;
    int    span;
    span = (n > DEPTH) ? DEPTH : n;
    for (int i = 0; i < beats; i++) begin
      beat.cmd = CMD_SEARCH;
      beat.entry_index = IDX_W'($urandom_range(DEPTH - 1));
      beat.data_value = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) begin
        // stray write, may break the ordering
        beat.cmd = CMD_WRITE;
      end else if (span > 0 && pick < 60) begin
        beat.data_value = entry_mirror[$urandom_range(span - 1)];
      end else if (span > 0 && pick < 80) begin
        beat.data_value = entry_mirror[$urandom_range(span - 1)] +
                          ($urandom_range(1) ? 1 : -1);
      end else if (pick < 86) begin
        beat.data_value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      end
      if ($urandom_range(39) == 0) drain(0);
      send_beat(beat, 1'b0, '0);
    end
  endtask

  function automatic void add_beat(logic cmd, int idx, logic signed [DATA_W-1:0] value,
                                   logic pinned, logic found, int pos);
    stim_row_t row;
    row.kind = ROW_BEAT;
    row.beat.cmd = cmd;
    row.beat.entry_index = idx[IDX_W-1:0];
    row.beat.data_value = value;
    row.pinned = pinned;
    row.answer.found = found;
    row.answer.position = pos[POS_W-1:0];
    row.count_value = 0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_count(int n);
    stim_row_t row;
    row.kind = ROW_COUNT;
    row.beat = '0;
    row.pinned = 1'b0;
    row.answer = '0;
    row.count_value = n;
    directed_rows.push_back(row);
  endfunction

  initial begin
    int phase;
    int n;
    int widest;

    // empty table straight after reset
    add_beat(CMD_SEARCH, 0, 0, 1'b1, 1'b0, 0);
    add_beat(CMD_SEARCH, 255, VAL_MIN, 1'b1, 1'b0, 0);
    add_beat(CMD_WRITE, 0, VAL_MIN, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 1, -1000, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 2, -1, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 3, 0, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 4, 5, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 5, 100, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 6, 1000000, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 7, VAL_MAX, 1'b0, 1'b0, 0);
    add_count(8);
    add_beat(CMD_SEARCH, 0, VAL_MIN, 1'b1, 1'b1, 0);
    add_beat(CMD_SEARCH, 0, VAL_MAX, 1'b1, 1'b1, 7);
    add_beat(CMD_SEARCH, 0, 0, 1'b1, 1'b1, 3);
    add_beat(CMD_SEARCH, 0, 7, 1'b0, 1'b0, 0);
    add_beat(CMD_SEARCH, 0, -5, 1'b0, 1'b0, 0);
    add_beat(CMD_WRITE, 255, 42, 1'b0, 1'b0, 0);
    // out of order entry, search still follows the same probes
    add_beat(CMD_WRITE, 2, VAL_MAX, 1'b0, 1'b0, 0);
    add_beat(CMD_SEARCH, 0, VAL_MAX, 1'b0, 1'b0, 0);
    add_beat(CMD_SEARCH, 0, -1, 1'b0, 1'b0, 0);
    add_count(1);
    add_beat(CMD_SEARCH, 0, 5, 1'b1, 1'b0, 0);
    add_count(0);
    add_beat(CMD_SEARCH, 0, VAL_MAX, 1'b1, 1'b0, 0);

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_COUNT) set_count(directed_rows[r].count_value);
      else send_beat(directed_rows[r].beat, directed_rows[r].pinned, directed_rows[r].answer);
    end

    // whole table, then a count past the depth on the same contents
    phase = 0;
    widest = DEPTH;
    idle_pct = idle_modes[phase % 3];
    set_count(DEPTH);
    fill_sorted(DEPTH);
    run_searches(DEPTH, 60);
    phase++;
    idle_pct = idle_modes[phase % 3];
    set_count(COUNT_ALL_ONES);
    run_searches(DEPTH, 40);
    phase++;

    while (items_sent < TARGET_ITEMS) begin
      idle_pct = idle_modes[phase % 3];
      if ($urandom_range(9) == 0) n = 0;
      else if ($urandom_range(3) == 0) n = $urandom_range(2, 1);
      else n = $urandom_range(48, 3);
      set_count(n);
      fill_sorted(n);
      run_searches(n, 2 * n + 12);
      phase++;
    end

    idle_pct = 0;
    drain(SETTLE_CYCLES);
    $display("covered %0d beats in %0d table settings, count up to %0d and saturated",
             items_sent, phase, widest);
    $display("%0d searches checked, %0d expected hits, %0d mismatches",
             searches, hits, errors);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sts_pkg.sv
rtl/core/sts_table.sv
rtl/core/sts_ctrl.sv
rtl/core/sorted_table_binary_search.sv
rtl/core/sts_chk.sv
dv/tb_top.sv
